FILE: rtl/core/dpxfb_pkg.sv
// ----------------------------------------------------------------------------
// dpxfb_pkg
// shared constants for the dpx frame boundary framer
// ----------------------------------------------------------------------------
package dpxfb_pkg;

    localparam logic [31:0] MAGIC_BE             = 32'h5344_5058;
    localparam logic [31:0] MAGIC_LE             = 32'h5850_4453;
    localparam logic [31:0] SIZE_POSITION        = 32'd20;
    localparam logic [31:0] MAGIC_LEN            = 32'd4;
    localparam logic [31:0] POSITION_MAX         = 32'hFFFF_FFFF;
    localparam logic [15:0] MIN_FRAME_SIZE_RESET = 16'd1664;
    localparam logic [2:0]  HOLD_DEPTH           = 3'd4;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

endpackage

FILE: rtl/core/dpx_frame_boundary_framer.sv
// ----------------------------------------------------------------------------
// output: a data byte leaves four items later; its result is registered and
//   shows in the cycle after the fifth byte is accepted
// throughput: one item per cycle unless stalled; a flush drains up to four
//   held bytes, one per free cycle from the drain register, input held off
// reset: rst_n asynchronous active low, clears framing state, min_frame_size
//   returns to 1664
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// dpx_frame_boundary_framer
// splits a byte stream into dpx frames, marking the last byte of each frame
// ----------------------------------------------------------------------------
module dpx_frame_boundary_framer
    import dpxfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,      // min_frame_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // in_byte
    input  logic        s_axis_tuser,     // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // out_byte
    output logic        m_axis_tlast      // last_of_frame
);

    logic [15:0] min_frame_size_reg;
    logic [31:0] recent_reg, recent_next;
    logic [2:0]  held_reg, held_next;
    logic        in_frame_reg, in_frame_next;
    logic        big_endian_reg, big_endian_next;
    logic [31:0] position_reg, position_next;
    logic [31:0] declared_reg, declared_next;
    logic [31:0] drain_bytes_reg;
    logic [2:0]  drain_cnt_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        in_acc;
    logic        is_flush;
    logic        emit;
    logic        mark;
    logic        magic_be;
    logic        magic_le;
    logic [31:0] position_inc;
    logic [31:0] size_word;
    logic [1:0]  drain_idx;
    logic [2:0]  drain_cnt_dec;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = out_free && (drain_cnt_reg == 3'd0);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_flush      = (s_axis_tuser == CMD_FLUSH);
    assign emit          = (held_reg >= HOLD_DEPTH);
    assign drain_cnt_dec = drain_cnt_reg - 3'd1;
    assign drain_idx     = drain_cnt_dec[1:0];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        recent_next     = {recent_reg[23:0], s_axis_tdata};
        held_next       = emit ? held_reg : held_reg + 3'd1;
        in_frame_next   = in_frame_reg;
        big_endian_next = big_endian_reg;
        position_next   = position_reg;
        declared_next   = declared_reg;
        mark            = 1'b0;
        magic_be        = (recent_next == MAGIC_BE);
        magic_le        = (recent_next == MAGIC_LE);
        position_inc    = (position_reg == POSITION_MAX) ? position_reg
                                                         : position_reg + 32'd1;
        size_word       = big_endian_reg ? recent_next
                        : {recent_next[7:0], recent_next[15:8],
                           recent_next[23:16], recent_next[31:24]};
        if (!in_frame_reg)
        begin
            if (magic_be || magic_le)
            begin
                in_frame_next   = 1'b1;
                big_endian_next = magic_be;
                position_next   = MAGIC_LEN;
            end
        end
        else
        begin
            position_next = position_inc;
            if (position_inc == SIZE_POSITION)
            begin
                declared_next = size_word;
                if (size_word <= {16'd0, min_frame_size_reg})
                begin
                    in_frame_next = 1'b0;
                end
            end
            else if (position_inc > SIZE_POSITION && position_inc >= declared_reg
                     && (magic_be || magic_le))
            begin
                mark            = emit;
                big_endian_next = magic_be;
                position_next   = MAGIC_LEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_frame_size_reg <= MIN_FRAME_SIZE_RESET;
            recent_reg         <= '0;
            held_reg           <= '0;
            in_frame_reg       <= 1'b0;
            big_endian_reg     <= 1'b0;
            position_reg       <= '0;
            declared_reg       <= '0;
            drain_bytes_reg    <= '0;
            drain_cnt_reg      <= '0;
            out_valid_reg      <= 1'b0;
            out_byte_reg       <= '0;
            out_last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                min_frame_size_reg <= cfg_wr_data;
            end

            // state update
            if (in_acc && is_flush)
            begin
                drain_bytes_reg <= recent_reg;
                drain_cnt_reg   <= held_reg;
                recent_reg      <= '0;
                held_reg        <= '0;
                in_frame_reg    <= 1'b0;
                big_endian_reg  <= 1'b0;
                position_reg    <= '0;
                declared_reg    <= '0;
            end
            else if (in_acc)
            begin
                recent_reg     <= recent_next;
                held_reg       <= held_next;
                in_frame_reg   <= in_frame_next;
                big_endian_reg <= big_endian_next;
                position_reg   <= position_next;
                declared_reg   <= declared_next;
            end

            // output register
            if (in_acc && !is_flush && emit)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= recent_reg[31:24];
                out_last_reg  <= mark;
            end
            else if (drain_cnt_reg != 3'd0 && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= drain_bytes_reg[8*drain_idx +: 8];
                out_last_reg  <= (drain_cnt_reg == 3'd1);
                drain_cnt_reg <= drain_cnt_dec;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/dpxfb_checker.sv
// ----------------------------------------------------------------------------
// dpxfb_checker
// port-level checks for the dpx frame boundary framer
// ----------------------------------------------------------------------------
module dpxfb_checker
    import dpxfb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // a blocked output holds off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // a fresh item comes from an accepted byte or from a drain
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready) || $past(!s_axis_tready))
        else $error("output item without a source");

    // a flush stops the input until its drain is over
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_FLUSH && !m_axis_tvalid
            |=> !m_axis_tvalid || m_axis_tlast || !s_axis_tready)
        else $error("input taken during flush drain");

endmodule

bind dpx_frame_boundary_framer dpxfb_checker u_dpxfb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
